/* rtl/arc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package arc_pkg;

    // Field widths; the MAC and IP widths are fixed by the ARP packet format
    localparam int MAC_W  = 48;
    localparam int IP_W   = 32;
    localparam int LIFE_W = 16;
    localparam int LEN_W  = 11;

    // Configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    localparam logic [1:0] REG_OWN_IP    = 2'd0;
    localparam logic [1:0] REG_OWN_MAC   = 2'd1;
    localparam logic [1:0] REG_FULL_LIFE = 2'd2;

    localparam logic [LIFE_W-1:0] FULL_LIFE_RESET = 16'd300;

    // Item kinds
    localparam logic ACT_PACKET = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // ARP header checks
    localparam logic [LEN_W-1:0] MIN_PKT_LEN = 11'd28;
    localparam logic [15:0]      HW_TYPE_ETH = 16'h0001;
    localparam logic [15:0]      PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]       HW_LEN_ETH  = 8'd6;
    localparam logic [7:0]       PROTO_LEN_V4 = 8'd4;
    localparam logic [15:0]      OP_REQUEST  = 16'd1;
    localparam logic [15:0]      OP_REPLY    = 16'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              action;
        logic [LEN_W-1:0]  arp_len;
        logic [15:0]       hw_type;
        logic [15:0]       proto_type;
        logic [7:0]        hw_len;
        logic [7:0]        proto_len;
        logic [15:0]       opcode;
        logic [MAC_W-1:0]  sender_mac;
        logic [IP_W-1:0]   sender_ip;
        logic [IP_W-1:0]   target_ip;
        logic [IP_W-1:0]   lookup_ip;
    } t_item;

    typedef struct packed {
        logic              ok;
        logic              send_reply;
        logic [MAC_W-1:0]  reply_mac;
        logic [IP_W-1:0]   reply_ip;
        logic [MAC_W-1:0]  found_mac;
    } t_result;

    typedef struct packed {
        logic              resolved;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [LIFE_W-1:0] lifetime;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [IP_W-1:0]   own_ip;
        logic [MAC_W-1:0]  own_mac;
        logic [LIFE_W-1:0] full_lifetime;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic rd_issue;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic needs_scan;
        logic last_issue;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/arc_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface arc_in_if;
    import arc_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [LEN_W-1:0]  arp_len;
    logic [15:0]       hw_type;
    logic [15:0]       proto_type;
    logic [7:0]        hw_len;
    logic [7:0]        proto_len;
    logic [15:0]       opcode;
    logic [MAC_W-1:0]  sender_mac;
    logic [IP_W-1:0]   sender_ip;
    logic [IP_W-1:0]   target_ip;
    logic [IP_W-1:0]   lookup_ip;

    modport source (
        output valid, action, arp_len, hw_type, proto_type, hw_len, proto_len,
               opcode, sender_mac, sender_ip, target_ip, lookup_ip,
        input  ready
    );

    modport sink (
        input  valid, action, arp_len, hw_type, proto_type, hw_len, proto_len,
               opcode, sender_mac, sender_ip, target_ip, lookup_ip,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/arc_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface arc_out_if;
    import arc_pkg::*;

    logic              valid;
    logic              ready;
    logic              ok;
    logic              send_reply;
    logic [MAC_W-1:0]  reply_mac;
    logic [IP_W-1:0]   reply_ip;
    logic [MAC_W-1:0]  found_mac;

    modport source (
        output valid, ok, send_reply, reply_mac, reply_ip, found_mac,
        input  ready
    );

    modport sink (
        input  valid, ok, send_reply, reply_mac, reply_ip, found_mac,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/arc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module arc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/arc_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module arc_cfg
    import arc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[CFG_ADDR_W-1:3];

    // Write registers in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_ip        <= '0;
            r_cfg.own_mac       <= '0;
            r_cfg.full_lifetime <= FULL_LIFE_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_OWN_IP:    r_cfg.own_ip        <= pwdata[IP_W-1:0];
                REG_OWN_MAC:   r_cfg.own_mac       <= pwdata[MAC_W-1:0];
                REG_FULL_LIFE: r_cfg.full_lifetime <= pwdata[LIFE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (w_idx)
            REG_OWN_IP:    prdata = {{(CFG_DATA_W-IP_W){1'b0}}, r_cfg.own_ip};
            REG_OWN_MAC:   prdata = {{(CFG_DATA_W-MAC_W){1'b0}}, r_cfg.own_mac};
            REG_FULL_LIFE: prdata = {{(CFG_DATA_W-LIFE_W){1'b0}}, r_cfg.full_lifetime};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/arc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module arc_ctrl
    import arc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  t_sts      i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.needs_scan ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.rd_issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTH
    a_reject_skips_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_sts.needs_scan) |=> (r_state == S_DONE))
        else $error("rejected packet entered the table scan");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_sts.last_issue) |=> (r_state == S_DRAIN))
        else $error("scan did not stop after the last entry");
`endif

endmodule

`default_nettype wire

/* rtl/arc_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module arc_dp
    import arc_pkg::*;
#(
    parameter int ENTRIES = 8,
    localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    input  t_item     i_item,
    input  t_cfg      i_cfg,
    input  wire logic i_out_ready,
    output logic      o_out_valid,
    output t_result   o_result
);

    t_item               r_item;
    logic                r_pkt_ok;
    logic [AW-1:0]       r_cnt;
    logic                r_rd_vld;
    logic [AW-1:0]       r_rd_idx;
    logic [ENTRIES-1:0]  r_valid;
    logic                r_found;
    logic [AW-1:0]       r_match_idx;
    logic                r_match_res;
    logic [MAC_W-1:0]    r_match_mac;
    logic                r_min_ok;
    logic [AW-1:0]       r_min_idx;
    logic [LIFE_W-1:0]   r_best;
    logic                r_out_vld;
    t_result             r_out;

    logic                w_pkt_ok;
    logic [ENTRY_W-1:0]  w_rdata;
    t_entry              w_ent;
    logic [IP_W-1:0]     w_key_ip;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    t_entry              w_wdata;
    t_result             w_res;

    // Header checks of an incoming packet
    assign w_pkt_ok = (i_item.arp_len >= MIN_PKT_LEN)
                   && (i_item.hw_type == HW_TYPE_ETH)
                   && (i_item.proto_type == PROTO_IPV4)
                   && (i_item.hw_len == HW_LEN_ETH)
                   && (i_item.proto_len == PROTO_LEN_V4)
                   && (i_item.target_ip == i_cfg.own_ip)
                   && ((i_item.opcode == OP_REQUEST) || (i_item.opcode == OP_REPLY));

    assign o_sts.needs_scan = (i_item.action == ACT_LOOKUP) || w_pkt_ok;
    assign o_sts.last_issue = (r_cnt == AW'(ENTRIES - 1));
    assign o_sts.out_free   = !r_out_vld || i_out_ready;

    // Cache table, one entry read per cycle during the scan
    arc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_cnt),
        .o_rdata (w_rdata)
    );

    // An entry never written reads as empty
    assign w_ent    = r_valid[r_rd_idx] ? t_entry'(w_rdata) : t_entry'('0);
    assign w_key_ip = (r_item.action == ACT_LOOKUP) ? r_item.lookup_ip : r_item.sender_ip;

    // Capture the item and step the read address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_issue;
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.rd_issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item   <= i_item;
            r_pkt_ok <= w_pkt_ok;
        end
        if (i_cmd.rd_issue) begin
            r_rd_idx <= r_cnt;
        end
    end

    // Track first IP match and smallest lifetime below full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found  <= 1'b0;
            r_min_ok <= 1'b0;
        end else if (i_cmd.load) begin
            r_found  <= 1'b0;
            r_min_ok <= 1'b0;
        end else if (r_rd_vld) begin
            if (!r_found && (w_ent.ip == w_key_ip)) begin
                r_found <= 1'b1;
            end
            if (w_ent.lifetime < r_best) begin
                r_min_ok <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_best <= i_cfg.full_lifetime;
        end else if (r_rd_vld) begin
            if (!r_found && (w_ent.ip == w_key_ip)) begin
                r_match_idx <= r_rd_idx;
                r_match_res <= w_ent.resolved;
                r_match_mac <= w_ent.mac;
            end
            if (w_ent.lifetime < r_best) begin
                r_best    <= w_ent.lifetime;
                r_min_idx <= r_rd_idx;
            end
        end
    end

    // Form the table update and the result
    always_comb begin
        w_we              = 1'b0;
        w_waddr           = r_found ? r_match_idx : r_min_idx;
        w_wdata.resolved  = 1'b1;
        w_wdata.ip        = w_key_ip;
        w_wdata.mac       = r_item.sender_mac;
        w_wdata.lifetime  = i_cfg.full_lifetime;
        w_res             = '0;
        if (r_item.action == ACT_LOOKUP) begin
            if (r_found && r_match_res) begin
                w_we          = i_cmd.finish;
                w_wdata.mac   = r_match_mac;
                w_res.ok      = 1'b1;
                w_res.found_mac = r_match_mac;
            end
        end else if (r_pkt_ok) begin
            w_we     = i_cmd.finish && (r_found || r_min_ok);
            w_res.ok = 1'b1;
            if (r_item.opcode == OP_REQUEST) begin
                w_res.send_reply = 1'b1;
                w_res.reply_mac  = r_item.sender_mac;
                w_res.reply_ip   = r_item.sender_ip;
            end
        end
    end

    // Mark written entries valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_we) begin
            r_valid[w_waddr] <= 1'b1;
        end
    end

    // Output register: hold the item until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

`ifndef SYNTH
    a_write_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (i_cmd.finish && (r_found || r_min_ok)))
        else $error("table written outside the finish step");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(i_cmd.finish))
        else $error("result appeared without a finished item");
`endif

endmodule

`default_nettype wire

/* rtl/arp_responder_cache_unit.sv */
// Flow: a packet that fails the header checks goes from acceptance straight to the done step;
//   any other item first scans the cache table and passes a drain step. The result is registered
//   once the done step finds the output free. A new item is accepted only after the last one has
//   finished; the scan reads the cache table through its one read port at one entry per cycle.
// Reset: synchronous, active low; registers return to their defaults and the per-entry
//   valid bits clear the cache at once, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module arp_responder_cache_unit
    import arc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    arc_in_if.sink                     i_in,
    arc_out_if.source                  o_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_sts    w_sts;
    t_item   w_item;
    t_result w_result;
    logic    w_out_valid;
    logic    w_in_ready;

    // Gather the input payload
    assign w_item.action        = i_in.action;
    assign w_item.arp_len       = i_in.arp_len;
    assign w_item.hw_type       = i_in.hw_type;
    assign w_item.proto_type    = i_in.proto_type;
    assign w_item.hw_len        = i_in.hw_len;
    assign w_item.proto_len     = i_in.proto_len;
    assign w_item.opcode        = i_in.opcode;
    assign w_item.sender_mac    = i_in.sender_mac;
    assign w_item.sender_ip     = i_in.sender_ip;
    assign w_item.target_ip     = i_in.target_ip;
    assign w_item.lookup_ip     = i_in.lookup_ip;
    assign i_in.ready           = w_in_ready;

    arc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    arc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    arc_dp #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_item      (w_item),
        .i_cfg       (w_cfg),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_result    (w_result)
    );

    // Drive the result channel
    assign o_out.valid      = w_out_valid;
    assign o_out.ok         = w_result.ok;
    assign o_out.send_reply = w_result.send_reply;
    assign o_out.reply_mac  = w_result.reply_mac;
    assign o_out.reply_ip   = w_result.reply_ip;
    assign o_out.found_mac  = w_result.found_mac;

endmodule

`default_nettype wire
